// ===== src/cpc_pkg.sv =====
package cpc_pkg;

  localparam int NumCorners = 4;

  // Corner order: (min_x,min_y), (max_x,min_y), (max_x,max_y), (min_x,max_y)
  localparam logic [NumCorners-1:0] CornerUseMaxX = 4'b0110;
  localparam logic [NumCorners-1:0] CornerUseMaxY = 4'b1100;

  localparam logic [1:0] VertFull = 2'd3;

  typedef struct packed {
    logic new_poly;
    logic edge_en;
    logic close_en;
    logic emit;
    logic too_few;
    logic in_cell;
  } cpc_ctl_t;

  typedef struct packed {
    logic [NumCorners-1:0] toggle;
    logic                  hit;
  } cpc_edge_res_t;

endpackage

// ===== src/cpc_in_if.sv =====
interface cpc_in_if #(parameter int COORD_BITS = 24);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] vert_x;
  logic signed [COORD_BITS-1:0] vert_y;
  logic signed [COORD_BITS-1:0] cell_min_x;
  logic signed [COORD_BITS-1:0] cell_min_y;
  logic signed [COORD_BITS-1:0] cell_max_x;
  logic signed [COORD_BITS-1:0] cell_max_y;
  logic                         first_vertex;
  logic                         last_vertex;

  modport source (
    output valid, vert_x, vert_y, cell_min_x, cell_min_y, cell_max_x, cell_max_y,
           first_vertex, last_vertex,
    input  ready
  );

  modport sink (
    input  valid, vert_x, vert_y, cell_min_x, cell_min_y, cell_max_x, cell_max_y,
           first_vertex, last_vertex,
    output ready
  );
endinterface

// ===== src/cpc_out_if.sv =====
interface cpc_out_if;
  logic valid;
  logic ready;
  logic overlaps;
  logic fully_inside;
  logic too_few_vertices;

  modport source (
    output valid, overlaps, fully_inside, too_few_vertices,
    input  ready
  );

  modport sink (
    input  valid, overlaps, fully_inside, too_few_vertices,
    output ready
  );
endinterface

// ===== src/cpc_edge.sv =====
module cpc_edge #(
  parameter int COORD_BITS = 24
) (
  input  logic signed [COORD_BITS-1:0] ax,
  input  logic signed [COORD_BITS-1:0] ay,
  input  logic signed [COORD_BITS-1:0] bx,
  input  logic signed [COORD_BITS-1:0] by,
  input  logic signed [COORD_BITS-1:0] min_x,
  input  logic signed [COORD_BITS-1:0] min_y,
  input  logic signed [COORD_BITS-1:0] max_x,
  input  logic signed [COORD_BITS-1:0] max_y,
  output cpc_pkg::cpc_edge_res_t       res
);
  import cpc_pkg::*;

  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * DW;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DW-1:0]         diff_t;
  typedef logic signed [PW-1:0]         prod_t;

  coord_t px [NumCorners];
  coord_t py [NumCorners];
  diff_t  cdx [NumCorners];
  diff_t  cdy [NumCorners];
  prod_t  pa [NumCorners];
  prod_t  pb [NumCorners];
  logic [NumCorners-1:0] crossing;
  diff_t  dx, dy;
  logic   x_pos, y_pos, x_zero, y_zero;
  diff_t  nxe, nxx, dxa, nye, nyx, dya;
  logic   ok_x, ok_y;
  prod_t  m0, m1, m2, m3;

  always_comb begin
    dx     = DW'(bx) - DW'(ax);
    dy     = DW'(by) - DW'(ay);
    x_pos  = bx > ax;
    y_pos  = by > ay;
    x_zero = bx == ax;
    y_zero = by == ay;
    for (int c = 0; c < NumCorners; c++) begin
      px[c]       = CornerUseMaxX[c] ? max_x : min_x;
      py[c]       = CornerUseMaxY[c] ? max_y : min_y;
      crossing[c] = (ay <= py[c] && by > py[c]) || (by <= py[c] && ay > py[c]);
      cdx[c]      = DW'(px[c]) - DW'(ax);
      cdy[c]      = DW'(py[c]) - DW'(ay);
      pa[c]       = PW'(cdx[c]) * PW'(dy);
      pb[c]       = PW'(cdy[c]) * PW'(dx);
      res.toggle[c] = crossing[c] && (y_pos ? (pa[c] < pb[c]) : (pa[c] > pb[c]));
    end
    // entry / exit numerators over a positive denominator
    nxe = x_pos ? DW'(min_x) - DW'(ax) : DW'(ax) - DW'(max_x);
    nxx = x_pos ? DW'(max_x) - DW'(ax) : DW'(ax) - DW'(min_x);
    dxa = x_pos ? dx : -dx;
    nye = y_pos ? DW'(min_y) - DW'(ay) : DW'(ay) - DW'(max_y);
    nyx = y_pos ? DW'(max_y) - DW'(ay) : DW'(ay) - DW'(min_y);
    dya = y_pos ? dy : -dy;
    ok_x = x_zero ? (min_x <= ax && ax <= max_x)
                  : (min_x <= max_x && (x_pos ? (min_x <= bx && ax <= max_x)
                                              : (bx <= max_x && min_x <= ax)));
    ok_y = y_zero ? (min_y <= ay && ay <= max_y)
                  : (min_y <= max_y && (y_pos ? (min_y <= by && ay <= max_y)
                                              : (by <= max_y && min_y <= ay)));
    m0 = PW'(nxe) * PW'(dya);
    m1 = PW'(nyx) * PW'(dxa);
    m2 = PW'(nye) * PW'(dxa);
    m3 = PW'(nxx) * PW'(dya);
    res.hit = ok_x && ok_y && (x_zero || y_zero || (m0 <= m1 && m2 <= m3));
  end

endmodule

// ===== src/cell_polygon_classifier_top.sv =====
// Polygon versus axis-aligned cell classifier.
// vertices: one polygon vertex per transfer, with the cell box (taken when
//   first_vertex is set) and first/last marks. A vertex without first_vertex
//   while no polygon is open starts one and keeps the previous box.
// results: one transfer per last_vertex with overlaps, fully_inside and
//   too_few_vertices.
// Throughput: one vertex per cycle unless the input holds (see Stall). Each
//   vertex is held in an input register; the new-edge and closing-edge tests
//   and the parity/hit update work from that register, and a last vertex
//   loads the result register, which marks the result valid. The edge units
//   run side by side, one for the new edge and one for the closing edge.
// Stall: vertices without a result keep flowing while a result waits; the
//   input holds only when a last vertex sits in the input register while the
//   result register is still full and results.ready is low.
// Reset: all polygon state, box and counters clear to zero; input register
//   empty.
module cell_polygon_classifier_top #(
  parameter int COORD_BITS = 24
) (
  input logic      clk,
  input logic      rst,
  cpc_in_if.sink   vertices,
  cpc_out_if.source results
);
  import cpc_pkg::*;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  logic   advance, take;
  logic   v1;
  logic   out_valid;

  coord_t start_x, start_y, prev_x, prev_y;
  coord_t box_min_x, box_min_y, box_max_x, box_max_y;
  logic [1:0] count;
  logic [NumCorners-1:0] corner_parity;
  logic   hit_seen;

  coord_t eff_min_x, eff_min_y, eff_max_x, eff_max_y;
  logic [1:0] count_next;
  cpc_ctl_t ctl_next;

  coord_t s1_prev_x, s1_prev_y, s1_v_x, s1_v_y, s1_start_x, s1_start_y;
  coord_t s1_min_x, s1_min_y, s1_max_x, s1_max_y;
  cpc_ctl_t ctl1;

  cpc_edge_res_t res0, res1;

  logic [NumCorners-1:0] par_a, par_f;
  logic   hit_a, hit_f;
  logic   overlaps, fully_inside, too_few_vertices;

  assign advance = !(v1 && ctl1.emit && out_valid && !results.ready);
  assign take    = vertices.valid && advance;
  assign vertices.ready = advance;

  always_comb begin
    eff_min_x = vertices.first_vertex ? vertices.cell_min_x : box_min_x;
    eff_min_y = vertices.first_vertex ? vertices.cell_min_y : box_min_y;
    eff_max_x = vertices.first_vertex ? vertices.cell_max_x : box_max_x;
    eff_max_y = vertices.first_vertex ? vertices.cell_max_y : box_max_y;
    ctl_next.new_poly = vertices.first_vertex || count == 2'd0;
    if (ctl_next.new_poly) begin
      count_next = 2'd1;
    end else if (count == VertFull) begin
      count_next = VertFull;
    end else begin
      count_next = count + 2'd1;
    end
    ctl_next.edge_en  = !ctl_next.new_poly;
    ctl_next.emit     = vertices.last_vertex;
    ctl_next.close_en = vertices.last_vertex && count_next == VertFull;
    ctl_next.too_few  = vertices.last_vertex && count_next != VertFull;
    ctl_next.in_cell  = vertices.vert_x >= eff_min_x && vertices.vert_x <= eff_max_x &&
                        vertices.vert_y >= eff_min_y && vertices.vert_y <= eff_max_y;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_x   <= '0;
      start_y   <= '0;
      prev_x    <= '0;
      prev_y    <= '0;
      box_min_x <= '0;
      box_min_y <= '0;
      box_max_x <= '0;
      box_max_y <= '0;
      count     <= 2'd0;
    end else if (take) begin
      if (ctl_next.new_poly) begin
        start_x <= vertices.vert_x;
        start_y <= vertices.vert_y;
      end
      prev_x    <= vertices.vert_x;
      prev_y    <= vertices.vert_y;
      box_min_x <= eff_min_x;
      box_min_y <= eff_min_y;
      box_max_x <= eff_max_x;
      box_max_y <= eff_max_y;
      count     <= vertices.last_vertex ? 2'd0 : count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (advance) begin
      v1 <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_prev_x  <= prev_x;
      s1_prev_y  <= prev_y;
      s1_v_x     <= vertices.vert_x;
      s1_v_y     <= vertices.vert_y;
      s1_start_x <= start_x;
      s1_start_y <= start_y;
      s1_min_x   <= eff_min_x;
      s1_min_y   <= eff_min_y;
      s1_max_x   <= eff_max_x;
      s1_max_y   <= eff_max_y;
      ctl1       <= ctl_next;
    end
  end

  cpc_edge #(.COORD_BITS(COORD_BITS)) u_edge_new (
    .ax    (s1_prev_x),
    .ay    (s1_prev_y),
    .bx    (s1_v_x),
    .by    (s1_v_y),
    .min_x (s1_min_x),
    .min_y (s1_min_y),
    .max_x (s1_max_x),
    .max_y (s1_max_y),
    .res   (res0)
  );

  cpc_edge #(.COORD_BITS(COORD_BITS)) u_edge_close (
    .ax    (s1_v_x),
    .ay    (s1_v_y),
    .bx    (s1_start_x),
    .by    (s1_start_y),
    .min_x (s1_min_x),
    .min_y (s1_min_y),
    .max_x (s1_max_x),
    .max_y (s1_max_y),
    .res   (res1)
  );

  always_comb begin
    par_a = (ctl1.new_poly ? '0 : corner_parity) ^ (ctl1.edge_en ? res0.toggle : '0);
    hit_a = (!ctl1.new_poly && hit_seen) || (ctl1.edge_en && res0.hit) || ctl1.in_cell;
    par_f = par_a ^ (ctl1.close_en ? res1.toggle : '0);
    hit_f = hit_a || (ctl1.close_en && res1.hit);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      corner_parity <= '0;
      hit_seen      <= 1'b0;
    end else if (v1 && advance) begin
      if (ctl1.emit) begin
        corner_parity <= '0;
        hit_seen      <= 1'b0;
      end else begin
        corner_parity <= par_a;
        hit_seen      <= hit_a;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (v1 && advance && ctl1.emit) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (v1 && advance && ctl1.emit) begin
      overlaps         <= !ctl1.too_few && (hit_f || (|par_f));
      fully_inside     <= !ctl1.too_few && (&par_f);
      too_few_vertices <= ctl1.too_few;
    end
  end

  assign results.valid            = out_valid;
  assign results.overlaps         = overlaps;
  assign results.fully_inside     = fully_inside;
  assign results.too_few_vertices = too_few_vertices;

  a_last_clears_count: assert property (@(posedge clk) disable iff (rst)
    take && vertices.last_vertex |=> count == 2'd0)
    else $error("vertex count not cleared after last vertex");

  a_close_xor_few: assert property (@(posedge clk) disable iff (rst)
    v1 |-> !(ctl1.close_en && ctl1.too_few))
    else $error("closing edge enabled on a short polygon");

  a_inside_overlaps: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!results.fully_inside || results.overlaps))
    else $error("containment without overlap");

  a_few_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && results.too_few_vertices |-> !results.overlaps && !results.fully_inside)
    else $error("short polygon reports a hit");

  a_hold_only_on_stall: assert property (@(posedge clk) disable iff (rst)
    !vertices.ready |-> out_valid && !results.ready)
    else $error("input held without an output stall");

endmodule
